// File: rtl/cpep_pkg.sv
// types, codes and helper functions for the constant pool entry parser
// no dependencies; used by cpep_step and the top level
`timescale 1ns / 1ps

package cpep_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 4;
  localparam int unsigned RoleW  = 3;
  localparam int unsigned ValueW = 32;
  localparam int unsigned AccW   = 24;
  localparam int unsigned LeftW  = 3;
  localparam int unsigned TextW  = 16;

  typedef enum logic [2:0] {
    PH_TAG   = 3'd0,
    PH_FIELD = 3'd1,
    PH_LEN   = 3'd2,
    PH_TEXT  = 3'd3,
    PH_HALT  = 3'd4
  } phase_e;

  localparam logic [KindW-1:0] KIND_UTF8    = 4'd0;
  localparam logic [KindW-1:0] KIND_INTEGER = 4'd1;
  localparam logic [KindW-1:0] KIND_FLOAT   = 4'd2;
  localparam logic [KindW-1:0] KIND_LONG    = 4'd3;
  localparam logic [KindW-1:0] KIND_DOUBLE  = 4'd4;
  localparam logic [KindW-1:0] KIND_CLASS   = 4'd5;
  localparam logic [KindW-1:0] KIND_STRING  = 4'd6;
  localparam logic [KindW-1:0] KIND_FIELD   = 4'd7;
  localparam logic [KindW-1:0] KIND_METHOD  = 4'd8;
  localparam logic [KindW-1:0] KIND_IMETHOD = 4'd9;
  localparam logic [KindW-1:0] KIND_NAMETYP = 4'd10;
  localparam logic [KindW-1:0] KIND_BAD     = 4'd15;

  localparam logic [ByteW-1:0] TAG_UTF8    = 8'd1;
  localparam logic [ByteW-1:0] TAG_INTEGER = 8'd3;
  localparam logic [ByteW-1:0] TAG_FLOAT   = 8'd4;
  localparam logic [ByteW-1:0] TAG_LONG    = 8'd5;
  localparam logic [ByteW-1:0] TAG_DOUBLE  = 8'd6;
  localparam logic [ByteW-1:0] TAG_CLASS   = 8'd7;
  localparam logic [ByteW-1:0] TAG_STRING  = 8'd8;
  localparam logic [ByteW-1:0] TAG_FIELD   = 8'd9;
  localparam logic [ByteW-1:0] TAG_METHOD  = 8'd10;
  localparam logic [ByteW-1:0] TAG_IMETHOD = 8'd11;
  localparam logic [ByteW-1:0] TAG_NAMETYP = 8'd12;

  localparam logic [RoleW-1:0] ROLE_FIRST  = 3'd0;
  localparam logic [RoleW-1:0] ROLE_SECOND = 3'd1;
  localparam logic [RoleW-1:0] ROLE_LENGTH = 3'd2;
  localparam logic [RoleW-1:0] ROLE_TEXT   = 3'd3;
  localparam logic [RoleW-1:0] ROLE_ERROR  = 3'd4;

  typedef struct packed {
    phase_e             phase;
    logic [KindW-1:0]   kind;
    logic [LeftW-1:0]   bytes_left;
    logic               second_pending;
    logic [AccW-1:0]    acc;
    logic [TextW-1:0]   text_left;
  } state_t;

  typedef struct packed {
    logic               last;
    logic [ValueW-1:0]  value;
    logic [RoleW-1:0]   role;
    logic [KindW-1:0]   kind;
  } result_t;

  function automatic logic [KindW-1:0] tag_to_kind(input logic [ByteW-1:0] tag);
    logic [KindW-1:0] k;
    case (tag)
      TAG_UTF8:    k = KIND_UTF8;
      TAG_INTEGER: k = KIND_INTEGER;
      TAG_FLOAT:   k = KIND_FLOAT;
      TAG_LONG:    k = KIND_LONG;
      TAG_DOUBLE:  k = KIND_DOUBLE;
      TAG_CLASS:   k = KIND_CLASS;
      TAG_STRING:  k = KIND_STRING;
      TAG_FIELD:   k = KIND_FIELD;
      TAG_METHOD:  k = KIND_METHOD;
      TAG_IMETHOD: k = KIND_IMETHOD;
      TAG_NAMETYP: k = KIND_NAMETYP;
      default:     k = KIND_BAD;
    endcase
    return k;
  endfunction

  function automatic logic [LeftW-1:0] field_size(input logic [KindW-1:0] kind);
    logic [LeftW-1:0] n;
    n = (kind >= KIND_INTEGER && kind <= KIND_DOUBLE) ? 3'd4 : 3'd2;
    return n;
  endfunction

  function automatic logic two_fields(input logic [KindW-1:0] kind);
    logic t;
    t = (kind == KIND_LONG) || (kind == KIND_DOUBLE) || (kind >= KIND_FIELD);
    return t;
  endfunction

endpackage

// File: rtl/cpep_step.sv
// next-state and result logic of the parser for one input byte
// depends on cpep_pkg
`timescale 1ns / 1ps

module cpep_step (
  input  cpep_pkg::state_t                 state_i,
  input  logic [cpep_pkg::ByteW-1:0]       byte_i,
  output cpep_pkg::state_t                 state_o,
  output logic                             res_valid_o,
  output cpep_pkg::result_t                res_o
);

  logic [cpep_pkg::KindW-1:0]  tag_kind;
  logic [cpep_pkg::ValueW-1:0] acc_full;
  logic [cpep_pkg::ValueW-1:0] len_full;
  logic [cpep_pkg::LeftW-1:0]  left_dec;
  logic [cpep_pkg::TextW-1:0]  text_dec;

  assign tag_kind = cpep_pkg::tag_to_kind(byte_i);
  assign acc_full = {state_i.acc, byte_i};
  assign len_full = {16'd0, state_i.acc[7:0], byte_i};
  assign left_dec = state_i.bytes_left - 3'd1;
  assign text_dec = state_i.text_left - 16'd1;

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (state_i.phase)
      cpep_pkg::PH_TAG: begin
        if (tag_kind == cpep_pkg::KIND_BAD) begin
          state_o.phase = cpep_pkg::PH_HALT;
          res_valid_o   = 1'b1;
          res_o.kind    = cpep_pkg::KIND_UTF8;
          res_o.role    = cpep_pkg::ROLE_ERROR;
          res_o.value   = {24'd0, byte_i};
          res_o.last    = 1'b1;
        end else begin
          state_o.kind = tag_kind;
          state_o.acc  = '0;
          if (tag_kind == cpep_pkg::KIND_UTF8) begin
            state_o.phase          = cpep_pkg::PH_LEN;
            state_o.bytes_left     = 3'd2;
            state_o.second_pending = 1'b0;
          end else begin
            state_o.phase          = cpep_pkg::PH_FIELD;
            state_o.bytes_left     = cpep_pkg::field_size(tag_kind);
            state_o.second_pending = cpep_pkg::two_fields(tag_kind);
          end
        end
      end
      cpep_pkg::PH_FIELD: begin
        if (left_dec != 3'd0) begin
          state_o.acc        = acc_full[cpep_pkg::AccW-1:0];
          state_o.bytes_left = left_dec;
        end else begin
          res_valid_o = 1'b1;
          res_o.kind  = state_i.kind;
          res_o.value = acc_full;
          state_o.acc = '0;
          if (state_i.second_pending) begin
            res_o.role             = cpep_pkg::ROLE_FIRST;
            res_o.last             = 1'b0;
            state_o.second_pending = 1'b0;
            state_o.bytes_left     = cpep_pkg::field_size(state_i.kind);
          end else begin
            res_o.role         = cpep_pkg::two_fields(state_i.kind) ? cpep_pkg::ROLE_SECOND
                                                                    : cpep_pkg::ROLE_FIRST;
            res_o.last         = 1'b1;
            state_o.bytes_left = left_dec;
            state_o.phase      = cpep_pkg::PH_TAG;
          end
        end
      end
      cpep_pkg::PH_LEN: begin
        state_o.bytes_left = left_dec;
        if (left_dec != 3'd0) begin
          state_o.acc = len_full[cpep_pkg::AccW-1:0];
        end else begin
          state_o.text_left = len_full[cpep_pkg::TextW-1:0];
          state_o.acc       = '0;
          res_valid_o       = 1'b1;
          res_o.kind        = cpep_pkg::KIND_UTF8;
          res_o.role        = cpep_pkg::ROLE_LENGTH;
          res_o.value       = len_full;
          res_o.last        = (len_full[cpep_pkg::TextW-1:0] == 16'd0);
          state_o.phase     = (len_full[cpep_pkg::TextW-1:0] == 16'd0) ? cpep_pkg::PH_TAG
                                                                       : cpep_pkg::PH_TEXT;
        end
      end
      cpep_pkg::PH_TEXT: begin
        state_o.text_left = text_dec;
        res_valid_o       = 1'b1;
        res_o.kind        = cpep_pkg::KIND_UTF8;
        res_o.role        = cpep_pkg::ROLE_TEXT;
        res_o.value       = {24'd0, byte_i};
        res_o.last        = (text_dec == 16'd0);
        if (text_dec == 16'd0) begin
          state_o.phase = cpep_pkg::PH_TAG;
        end
      end
      default: begin
        state_o.phase = cpep_pkg::PH_HALT;
      end
    endcase
  end

endmodule

// File: rtl/class_constant_pool_entry_parser_unit.sv
// top level of the constant pool entry parser: input register, parser state, result register
// depends on cpep_pkg and cpep_step
//
// channel   direction  tdata bits (low first)   tuser bits (low first)            tlast
// s_axis    in         in_byte[7:0]             -                                 -
// m_axis    out        field_value[31:0]        entry_kind[3:0] field_role[6:4]   entry_last
//
// one input byte per cycle sustained while m_axis_tready stays high
// a byte passes from the input register through the parser step into the result register
// reset puts the parser in tag phase with empty input and result registers
// a stalled result holds the pipe; one byte can wait in the input register meanwhile
// after an invalid tag the error item is sent and all later items are dropped until reset
`timescale 1ns / 1ps

module class_constant_pool_entry_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // field_value[31:0]
  output logic [6:0]  m_axis_tuser,   // entry_kind[3:0], field_role[6:4]
  output logic        m_axis_tlast    // entry_last
);

  logic                         in_valid_q;
  logic [cpep_pkg::ByteW-1:0]   in_byte_q;
  cpep_pkg::state_t             state_q;
  cpep_pkg::state_t             state_d;
  logic                         res_valid;
  cpep_pkg::result_t            res_d;
  cpep_pkg::result_t            res_q;
  logic                         out_valid_q;
  logic                         advance;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  cpep_step u_step (
    .state_i     (state_q),
    .byte_i      (in_byte_q),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: cpep_pkg::PH_TAG, default: '0};
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q && res_valid;
        if (in_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q.value;
  assign m_axis_tuser  = {res_q.role, res_q.kind};
  assign m_axis_tlast  = res_q.last;

endmodule
